FILE: hw/rtl/max_heap_priority_queue_top_assert.svh
// Assertion macros for the max-heap priority queue
// Used by max_heap_priority_queue_top; needs no other file
`ifndef MAX_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH

// property checked on every rising edge outside reset
`define MHPQ_CHECK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be seen outside reset
`define MHPQ_NEVER(lbl, clk, rst, cond, msg) \
   `MHPQ_CHECK(lbl, clk, rst, !(cond), msg)

`endif

FILE: hw/rtl/mhpq_pkg.sv
// Shared types and constants of the max-heap priority queue
// No dependencies; compiled before every other file
`default_nettype none

package mhpq_pkg;

   // payload widths fixed by the channel definitions
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int CNT_W    = 11;

   // operation code of a request
   localparam logic OP_INSERT  = 1'b0;
   localparam logic OP_EXTRACT = 1'b1;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_code_type;

   // controller to datapath commands
   typedef struct packed {
      logic start;
      logic up_check;
      logic up_cmp;
      logic ex_root;
      logic ex_last;
      logic ex_load;
      logic dn_left;
      logic dn_right;
      logic dn_cmp;
      logic load_rsp;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic req_insert;
      logic full;
      logic empty;
      logic at_root;
      logic no_left;
      logic move_up;
      logic move_down;
   } stat_type;

endpackage

`default_nettype wire

FILE: hw/rtl/mhpq_if.sv
// Request and response channel interfaces of the max-heap priority queue
// Depends on mhpq_pkg
`default_nettype none

interface mhpq_req_if;
   import mhpq_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      op;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

interface mhpq_rsp_if;
   import mhpq_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] max_value;
   logic [STATUS_W-1:0]       status;
   logic [CNT_W-1:0]          entry_count;

   modport source (output valid, output max_value, output status, output entry_count,
                   input ready);
   modport sink   (input valid, input max_value, input status, input entry_count,
                   output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/mhpq_ctrl.sv
// Sequencing state machine of the max-heap priority queue
// Depends on mhpq_pkg; drives commands into mhpq_datapath
`default_nettype none

module mhpq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  mhpq_pkg::stat_type stat,
   output mhpq_pkg::cmd_type  cmd
);
   import mhpq_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE     = 10'b00_0000_0001,
      S_UP_CHECK = 10'b00_0000_0010,
      S_UP_CMP   = 10'b00_0000_0100,
      S_EX_ROOT  = 10'b00_0000_1000,
      S_EX_LAST  = 10'b00_0001_0000,
      S_EX_LOAD  = 10'b00_0010_0000,
      S_DN_LEFT  = 10'b00_0100_0000,
      S_DN_RIGHT = 10'b00_1000_0000,
      S_DN_CMP   = 10'b01_0000_0000,
      S_FINISH   = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // next state and commands
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               if (stat.req_insert) begin
                  state_in = stat.full ? S_FINISH : S_UP_CHECK;
               end else begin
                  state_in = stat.empty ? S_FINISH : S_EX_ROOT;
               end
            end
         end
         S_UP_CHECK: begin
            cmd.up_check = 1'b1;
            state_in     = stat.at_root ? S_FINISH : S_UP_CMP;
         end
         S_UP_CMP: begin
            cmd.up_cmp = 1'b1;
            state_in   = stat.move_up ? S_UP_CHECK : S_FINISH;
         end
         S_EX_ROOT: begin
            cmd.ex_root = 1'b1;
            state_in    = S_EX_LAST;
         end
         S_EX_LAST: begin
            // count is already decremented: empty means the root was the last entry
            cmd.ex_last = 1'b1;
            state_in    = stat.empty ? S_FINISH : S_EX_LOAD;
         end
         S_EX_LOAD: begin
            cmd.ex_load = 1'b1;
            state_in    = S_DN_LEFT;
         end
         S_DN_LEFT: begin
            cmd.dn_left = 1'b1;
            state_in    = stat.no_left ? S_FINISH : S_DN_RIGHT;
         end
         S_DN_RIGHT: begin
            cmd.dn_right = 1'b1;
            state_in     = S_DN_CMP;
         end
         S_DN_CMP: begin
            cmd.dn_cmp = 1'b1;
            state_in   = stat.move_down ? S_DN_LEFT : S_FINISH;
         end
         S_FINISH: begin
            // hand over once the response register is free or being drained
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/mhpq_datapath.sv
// Heap memory, sift registers and response payload of the max-heap priority queue
// Depends on mhpq_pkg; commanded by mhpq_ctrl
`default_nettype none

module mhpq_datapath #(
   parameter int DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mhpq_pkg::cmd_type                   cmd,
   input  logic                                req_op,
   input  logic signed [mhpq_pkg::VALUE_W-1:0] req_value,
   output mhpq_pkg::stat_type                  stat,
   output logic signed [mhpq_pkg::VALUE_W-1:0] rsp_max_value,
   output logic [mhpq_pkg::STATUS_W-1:0]       rsp_status,
   output logic [mhpq_pkg::CNT_W-1:0]          rsp_entry_count
);
   import mhpq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int LW = AW + 2;

   // heap storage, one write and one registered read per cycle
   logic signed [VALUE_W-1:0] heap_mem [DEPTH];
   logic signed [VALUE_W-1:0] rd_data_ff;
   logic [AW-1:0]             rd_addr;
   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic signed [VALUE_W-1:0] wr_data;

   // sift state and response
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic [AW-1:0]             idx_ff, idx_in;
   logic signed [VALUE_W-1:0] val_ff, val_in;
   logic signed [VALUE_W-1:0] child_ff, child_in;
   logic signed [VALUE_W-1:0] result_ff, result_in;
   status_code_type           status_ff, status_in;
   logic signed [VALUE_W-1:0] out_value_ff, out_value_in;
   status_code_type           out_status_ff, out_status_in;
   logic [CNT_W-1:0]          out_count_ff, out_count_in;

   // index arithmetic
   logic [AW-1:0]             parent_idx;
   logic [LW-1:0]             left_ext;
   logic [LW-1:0]             right_ext;
   logic [LW-1:0]             cnt_ext;
   logic                      right_ok;
   logic signed [VALUE_W-1:0] best_val;
   logic [AW-1:0]             best_idx;
   logic                      is_full;
   logic                      is_empty;

   assign parent_idx = (idx_ff - AW'(1)) >> 1;
   assign left_ext   = {1'b0, idx_ff, 1'b1};
   assign right_ext  = left_ext + LW'(1);
   assign cnt_ext    = LW'(cnt_ff);
   assign right_ok   = right_ext < cnt_ext;
   assign is_full    = (cnt_ff == CW'(DEPTH));
   assign is_empty   = (cnt_ff == '0);

   // larger child, left wins a tie; right data is on the read port during dn_cmp
   always_comb begin
      best_val = child_ff;
      best_idx = left_ext[AW-1:0];
      if (right_ok && (rd_data_ff > child_ff)) begin
         best_val = rd_data_ff;
         best_idx = right_ext[AW-1:0];
      end
   end

   // status toward the controller
   always_comb begin
      stat            = '0;
      stat.req_insert = (req_op == OP_INSERT);
      stat.full       = is_full;
      stat.empty      = is_empty;
      stat.at_root    = (idx_ff == '0);
      stat.no_left    = (left_ext >= cnt_ext);
      stat.move_up    = (val_ff > rd_data_ff);
      stat.move_down  = (best_val > val_ff);
   end

   // memory read address
   always_comb begin
      rd_addr = '0;
      if (cmd.ex_root) begin
         rd_addr = '0;
      end else if (cmd.up_check) begin
         rd_addr = parent_idx;
      end else if (cmd.ex_last) begin
         rd_addr = cnt_ff[AW-1:0];
      end else if (cmd.dn_left) begin
         rd_addr = left_ext[AW-1:0];
      end else if (cmd.dn_right) begin
         rd_addr = right_ext[AW-1:0];
      end
   end

   // memory write: either the moving value lands or a neighbor shifts into the hole
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = val_ff;
      if (cmd.up_check && stat.at_root) begin
         wr_en = 1'b1;
      end else if (cmd.up_cmp) begin
         wr_en = 1'b1;
         if (stat.move_up) begin
            wr_data = rd_data_ff;
         end
      end else if (cmd.dn_left && stat.no_left) begin
         wr_en = 1'b1;
      end else if (cmd.dn_cmp) begin
         wr_en = 1'b1;
         if (stat.move_down) begin
            wr_data = best_val;
         end
      end
   end

   // next values of the sift and response registers
   always_comb begin
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      val_in        = val_ff;
      child_in      = child_ff;
      result_in     = result_ff;
      status_in     = status_ff;
      out_value_in  = out_value_ff;
      out_status_in = out_status_ff;
      out_count_in  = out_count_ff;
      if (cmd.start) begin
         result_in = '0;
         val_in    = req_value;
         status_in = ST_OK;
         if (req_op == OP_INSERT) begin
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               idx_in = cnt_ff[AW-1:0];
               cnt_in = cnt_ff + CW'(1);
            end
         end else begin
            if (is_empty) begin
               status_in = ST_EMPTY;
            end else begin
               cnt_in = cnt_ff - CW'(1);
            end
         end
      end
      if (cmd.up_cmp && stat.move_up) begin
         idx_in = parent_idx;
      end
      if (cmd.ex_last) begin
         result_in = rd_data_ff;
      end
      if (cmd.ex_load) begin
         val_in = rd_data_ff;
         idx_in = '0;
      end
      if (cmd.dn_right) begin
         child_in = rd_data_ff;
      end
      if (cmd.dn_cmp && stat.move_down) begin
         idx_in = best_idx;
      end
      if (cmd.load_rsp) begin
         out_value_in  = result_ff;
         out_status_in = status_ff;
         out_count_in  = CNT_W'(cnt_ff);
      end
   end

   // entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      val_ff        <= val_in;
      child_ff      <= child_in;
      result_ff     <= result_in;
      status_ff     <= status_in;
      out_value_ff  <= out_value_in;
      out_status_ff <= out_status_in;
      out_count_ff  <= out_count_in;
   end

   // heap memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= heap_mem[rd_addr];
   end

   assign rsp_max_value   = out_value_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_entry_count = out_count_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/max_heap_priority_queue_top.sv
// Top level of the max-heap priority queue: controller, datapath, assertions
// Depends on mhpq_pkg, mhpq_if, mhpq_ctrl, mhpq_datapath and the assertion header
//
//  channel  | direction | payload                          | handshake
//  ---------+-----------+----------------------------------+-------------
//  req_ch   | in        | op, value                        | valid/ready
//  rsp_ch   | out       | max_value, status, entry_count   | valid/ready
//
// one request at a time; the heap memory's one read port sets the pace
// insert: per level the value climbs, read parent, then compare
// extract: read root, read last entry, load it, then per level descended read left, read right, compare
// full or empty refusals skip the sift; reset clears the count only, no clearing pass
// a new request is taken while the previous response still waits on rsp_ch.ready
`default_nettype none

`include "max_heap_priority_queue_top_assert.svh"

module max_heap_priority_queue_top #(
   parameter int DEPTH = 1024
) (
   input logic       clock,
   input logic       reset,
   mhpq_req_if.sink  req_ch,
   mhpq_rsp_if.source rsp_ch
);
   import mhpq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencing
   mhpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // heap storage and arithmetic
   mhpq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_op          (req_ch.op),
      .req_value       (req_ch.value),
      .stat            (stat),
      .rsp_max_value   (rsp_ch.max_value),
      .rsp_status      (rsp_ch.status),
      .rsp_entry_count (rsp_ch.entry_count)
   );

   // checks
   `MHPQ_CHECK(a_one_at_a_time, clock, reset, req_ch.valid && req_ch.ready |=> !req_ch.ready, "request accepted while previous one still in work")
   `MHPQ_CHECK(a_full_count, clock, reset, rsp_ch.valid && rsp_ch.status == ST_FULL |-> rsp_ch.entry_count == CNT_W'(DEPTH), "full status with count below depth")
   `MHPQ_CHECK(a_empty_count, clock, reset, rsp_ch.valid && rsp_ch.status == ST_EMPTY |-> rsp_ch.entry_count == '0, "empty status with nonzero count")
   `MHPQ_NEVER(a_refusal_zero, clock, reset, rsp_ch.valid && rsp_ch.status != ST_OK && rsp_ch.max_value != '0, "refused request returned a nonzero value")

endmodule

`default_nettype wire
